// File: sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, codes and defaults for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned NumPagesDef   = 4096;
  localparam int unsigned OrderCountDef = 11;

  // Wide enough for any page index, plus one block size, at up to 65536 pages
  localparam int unsigned AW        = 17;
  localparam int unsigned OW        = 4;   // order field width
  localparam int unsigned PAGE_W    = 12;  // page index field width
  localparam int unsigned CFG_W     = 13;  // total_pages width
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_CLR_START,
    OP_CLR,
    OP_FIND,
    OP_AUNLINK,
    OP_SPLIT,
    OP_PUSH_A,
    OP_PUSH_B,
    OP_RD_META,
    OP_FCHK,
    OP_BUDDY,
    OP_MERGE,
    OP_INIT_STEP,
    OP_DONE
  } dp_op_e;

  typedef struct packed {
    logic found;
    logic split_more;
    logic free_ok;
    logic merge;
    logic init_done;
    logic init_fit;
    logic clr_last;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic          free;
    logic [OW-1:0] ord;
  } meta_t;

endpackage

// File: sv/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy allocator over a page array with per-order LIFO free lists.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Moves
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | request: cmd, page_index, order
//  m_axis   | out       | result: ok, page_index_res (one per request)
//  cfg      | in        | write of total_pages (no read-back)
//
// Allocate and free are both paced by the single registered read port of the
// link memories. Initialise sweeps the block table, then frees its blocks one by
// one. After reset the same sweep runs before the first request is taken. A
// result waits in an output register, so the next request is taken while it is
// still unread.
//
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int unsigned NUM_PAGES   = NumPagesDef,
  parameter int unsigned ORDER_COUNT = OrderCountDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] cmd, [13:2] page_index, [17:14] order, [23:18] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] ok, [12:1] page_index_res, [15:13] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  logic [CFG_W-1:0]  total_pages_q;
  dp_op_e            op;
  dp_status_t        status;
  cmd_e              req_cmd;
  logic              res_ok;
  logic [PAGE_W-1:0] res_page;

  // Hold the page count for the next initialise
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_pages_q <= CFG_W'(4096);
    end else if (cfg_we_i) begin
      total_pages_q <= cfg_wdata_i;
    end
  end

  assign req_cmd = cmd_e'(s_axis_tdata[CMD_W-1:0]);

  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_cmd_i   (req_cmd),
    .status_i    (status),
    .op_o        (op)
  );

  bpa_datapath #(
    .NUM_PAGES   (NUM_PAGES),
    .ORDER_COUNT (ORDER_COUNT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .status_o      (status),
    .in_page_i     (s_axis_tdata[CMD_W+PAGE_W-1:CMD_W]),
    .in_order_i    (s_axis_tdata[CMD_W+PAGE_W+OW-1:CMD_W+PAGE_W]),
    .total_pages_i (total_pages_q),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_ok_o      (res_ok),
    .out_page_o    (res_page)
  );

  // Pack the result, pad to whole bytes
  assign m_axis_tdata = {(OUT_DATA_W - PAGE_W - 1)'(0), res_page, res_ok};

endmodule

// File: sv/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for allocate, free and initialise requests.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  cmd_e       req_cmd_i,
  input  dp_status_t status_i,
  output dp_op_e     op_o
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CLRSTART = 4'd2;
  localparam logic [3:0] S_FIND     = 4'd3;
  localparam logic [3:0] S_AUNLINK  = 4'd4;
  localparam logic [3:0] S_SPLIT    = 4'd5;
  localparam logic [3:0] S_PUSHA    = 4'd6;
  localparam logic [3:0] S_PUSHB    = 4'd7;
  localparam logic [3:0] S_RDMETA   = 4'd8;
  localparam logic [3:0] S_FCHK     = 4'd9;
  localparam logic [3:0] S_BUDDY    = 4'd10;
  localparam logic [3:0] S_MERGE    = 4'd11;
  localparam logic [3:0] S_INIT     = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0] state_q, state_d;
  cmd_e       mode_q, mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      mode_q  <= CMD_NONE;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    op_o        = OP_IDLE;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        op_o = OP_CLR;
        if (status_i.clr_last) begin
          state_d = (mode_q == CMD_INIT) ? S_INIT : S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_o   = OP_LOAD;
          mode_d = req_cmd_i;
          unique case (req_cmd_i)
            CMD_ALLOC: state_d = S_FIND;
            CMD_FREE:  state_d = S_RDMETA;
            CMD_INIT:  state_d = S_CLRSTART;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_CLRSTART: begin
        op_o    = OP_CLR_START;
        state_d = S_CLEAR;
      end
      S_FIND: begin
        op_o    = OP_FIND;
        state_d = status_i.found ? S_AUNLINK : S_DONE;
      end
      S_AUNLINK: begin
        op_o    = OP_AUNLINK;
        state_d = status_i.split_more ? S_SPLIT : S_DONE;
      end
      S_SPLIT: begin
        op_o    = OP_SPLIT;
        state_d = S_PUSHA;
      end
      S_PUSHA: begin
        op_o    = OP_PUSH_A;
        state_d = S_PUSHB;
      end
      S_PUSHB: begin
        op_o = OP_PUSH_B;
        priority if (mode_q == CMD_ALLOC) begin
          state_d = status_i.split_more ? S_SPLIT : S_DONE;
        end else if (mode_q == CMD_INIT) begin
          state_d = S_INIT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RDMETA: begin
        op_o    = OP_RD_META;
        state_d = S_FCHK;
      end
      S_FCHK: begin
        op_o    = OP_FCHK;
        state_d = status_i.free_ok ? S_BUDDY : S_DONE;
      end
      S_BUDDY: begin
        op_o    = OP_BUDDY;
        state_d = S_MERGE;
      end
      S_MERGE: begin
        op_o    = OP_MERGE;
        state_d = status_i.merge ? S_BUDDY : S_PUSHA;
      end
      S_INIT: begin
        op_o = OP_INIT_STEP;
        priority if (status_i.init_done) begin
          state_d = S_DONE;
        end else if (status_i.init_fit) begin
          state_d = S_BUDDY;
        end else begin
          state_d = S_INIT;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          op_o    = OP_DONE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: sv/bpa_datapath.sv
// ----------------------------------------------------------------------------
// bpa_datapath
// Free-list heads, link and block memories, and the result register.
// ----------------------------------------------------------------------------
module bpa_datapath import bpa_pkg::*; #(
  parameter int unsigned NUM_PAGES   = NumPagesDef,
  parameter int unsigned ORDER_COUNT = OrderCountDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_op_e            op_i,
  output dp_status_t        status_o,
  input  logic [PAGE_W-1:0] in_page_i,
  input  logic [OW-1:0]     in_order_i,
  input  logic [CFG_W-1:0]  total_pages_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              out_ok_o,
  output logic [PAGE_W-1:0] out_page_o
);

  localparam int unsigned PW  = $clog2(NUM_PAGES);
  localparam int unsigned LW  = PW + 1;
  localparam int unsigned HIW = $clog2(ORDER_COUNT);
  localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);
  localparam logic [AW-1:0] NPG = AW'(NUM_PAGES);
  localparam logic [OW:0]   OCN = (OW+1)'(ORDER_COUNT);

  meta_t         meta_mem [NUM_PAGES];
  logic [LW-1:0] next_mem [NUM_PAGES];
  logic [LW-1:0] prev_mem [NUM_PAGES];

  logic [LW-1:0] head_q [ORDER_COUNT];
  logic [PW-1:0] clr_q;
  logic          out_vld_q;

  logic [AW-1:0] idx_q, p_q, n_q, pq_q, b_q;
  logic [OW-1:0] o_q, c_q, io_q, po_q;
  logic [LW-1:0] h_q;
  logic          cont_q, ok_q, out_ok_q;
  logic [PAGE_W-1:0] res_q, out_res_q;

  meta_t         meta_rd_q;
  logic [LW-1:0] next_rd_q, prev_rd_q;

  // Memory port signals
  logic          meta_we, next_we, prev_we;
  logic [PW-1:0] meta_wa, next_wa, prev_wa;
  meta_t         meta_wd;
  logic [LW-1:0] next_wd, prev_wd;
  logic [PW-1:0] meta_ra, link_ra;

  // Decode helpers
  logic          found;
  logic [OW-1:0] fc;
  logic [AW-1:0] buddy, step_o, step_io;
  logic [OW-1:0] c_dec;
  logic          merge, free_ok, init_done, init_fit;
  logic          nx_vld, pv_vld, h_vld;

  always_comb begin
    found = 1'b0;
    fc    = '0;
    for (int i = ORDER_COUNT - 1; i >= 0; i--) begin
      if (OW'(i) >= o_q && head_q[i] < NIL) begin
        found = 1'b1;
        fc    = OW'(i);
      end
    end
  end

  assign step_o    = AW'(1) << o_q;
  assign step_io   = AW'(1) << io_q;
  assign buddy     = idx_q ^ step_o;
  assign c_dec     = c_q - OW'(1);
  assign nx_vld    = next_rd_q < NIL;
  assign pv_vld    = prev_rd_q < NIL;
  assign h_vld     = h_q < NIL;
  assign merge     = cont_q && meta_rd_q.free && (meta_rd_q.ord == o_q);
  assign free_ok   = ({1'b0, o_q} < OCN) && ((idx_q + step_o) <= NPG) && !meta_rd_q.free;
  assign init_done = p_q >= n_q;
  assign init_fit  = (n_q - p_q) >= step_io;

  assign status_o.found      = found;
  assign status_o.split_more = c_q > o_q;
  assign status_o.free_ok    = free_ok;
  assign status_o.merge      = merge;
  assign status_o.init_done  = init_done;
  assign status_o.init_fit   = init_fit;
  assign status_o.clr_last   = clr_q == PW'(NUM_PAGES - 1);
  assign status_o.out_free   = !out_vld_q || out_ready_i;

  always_comb begin
    meta_we = 1'b0;
    meta_wa = pq_q[PW-1:0];
    meta_wd = '0;
    next_we = 1'b0;
    next_wa = pq_q[PW-1:0];
    next_wd = h_q;
    prev_we = 1'b0;
    prev_wa = pq_q[PW-1:0];
    prev_wd = NIL;
    meta_ra = idx_q[PW-1:0];
    link_ra = b_q[PW-1:0];
    unique case (op_i)
      OP_CLR: begin
        meta_we = 1'b1;
        meta_wa = clr_q;
      end
      OP_FIND: begin
        link_ra = head_q[fc[HIW-1:0]][PW-1:0];
      end
      OP_AUNLINK: begin
        meta_we = 1'b1;
        meta_wa = p_q[PW-1:0];
        prev_we = nx_vld;
        prev_wa = next_rd_q[PW-1:0];
        prev_wd = NIL;
      end
      OP_PUSH_A: begin
        meta_we = 1'b1;
        meta_wd = '{free: 1'b1, ord: po_q};
        next_we = 1'b1;
        next_wd = head_q[po_q[HIW-1:0]];
        prev_we = 1'b1;
      end
      OP_PUSH_B: begin
        prev_we = h_vld;
        prev_wa = h_q[PW-1:0];
        prev_wd = pq_q[LW-1:0];
      end
      OP_BUDDY: begin
        meta_ra = buddy[PW-1:0];
        link_ra = buddy[PW-1:0];
      end
      OP_MERGE: begin
        meta_we = merge;
        meta_wa = b_q[PW-1:0];
        next_we = merge && pv_vld;
        next_wa = prev_rd_q[PW-1:0];
        next_wd = next_rd_q;
        prev_we = merge && nx_vld;
        prev_wa = next_rd_q[PW-1:0];
        prev_wd = prev_rd_q;
      end
      default: ;
    endcase
  end

  // Memories: one write and one registered read each per cycle
  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    meta_rd_q <= meta_mem[meta_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_rd_q <= next_mem[link_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_rd_q <= prev_mem[link_ra];
  end

  // Control state: list heads, clear counter, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ORDER_COUNT; i++) begin
        head_q[i] <= NIL;
      end
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      unique case (op_i)
        OP_CLR_START: begin
          for (int i = 0; i < ORDER_COUNT; i++) begin
            head_q[i] <= NIL;
          end
          clr_q <= '0;
        end
        OP_CLR:     clr_q <= clr_q + PW'(1);
        OP_AUNLINK: head_q[c_q[HIW-1:0]] <= next_rd_q;
        OP_PUSH_B:  head_q[po_q[HIW-1:0]] <= pq_q[LW-1:0];
        OP_MERGE: begin
          if (merge && !pv_vld) begin
            head_q[o_q[HIW-1:0]] <= next_rd_q;
          end
        end
        default: ;
      endcase
      if (op_i == OP_DONE) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD: begin
        idx_q <= AW'(in_page_i);
        o_q   <= in_order_i;
        ok_q  <= 1'b0;
        res_q <= '0;
      end
      OP_CLR_START: begin
        p_q  <= '0;
        io_q <= OW'(ORDER_COUNT - 1);
        n_q  <= (AW'(total_pages_i) > NPG) ? NPG : AW'(total_pages_i);
      end
      OP_FIND: begin
        c_q <= fc;
        p_q <= AW'(head_q[fc[HIW-1:0]]);
      end
      OP_AUNLINK: begin
        ok_q  <= 1'b1;
        res_q <= p_q[PAGE_W-1:0];
      end
      OP_SPLIT: begin
        c_q  <= c_dec;
        po_q <= c_dec;
        pq_q <= p_q + (AW'(1) << c_dec);
      end
      OP_PUSH_A: h_q <= head_q[po_q[HIW-1:0]];
      OP_FCHK: begin
        if (free_ok) begin
          ok_q <= 1'b1;
        end
      end
      OP_BUDDY: begin
        b_q    <= buddy;
        cont_q <= (({1'b0, o_q} + (OW+1)'(1)) < OCN) && (buddy < NPG);
      end
      OP_MERGE: begin
        if (merge) begin
          idx_q <= idx_q & b_q;
          o_q   <= o_q + OW'(1);
        end else begin
          pq_q <= idx_q;
          po_q <= o_q;
        end
      end
      OP_INIT_STEP: begin
        priority if (init_done) begin
          ok_q <= 1'b1;
        end else if (init_fit) begin
          idx_q <= p_q;
          o_q   <= io_q;
          p_q   <= p_q + step_io;
        end else begin
          io_q <= io_q - OW'(1);
        end
      end
      OP_DONE: begin
        out_ok_q  <= ok_q;
        out_res_q <= res_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign out_ok_o    = out_ok_q;
  assign out_page_o  = out_res_q;

endmodule

// File: dv/buddy_page_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_checker
// Watches both stream channels and the config port, tracks the free lists of
// its own buddy allocator and compares every result with the oldest one due.
// ----------------------------------------------------------------------------
module buddy_page_allocator_checker import bpa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int NP   = 4096;
  localparam int NORD = 11;
  localparam int NIL  = NP;

  typedef struct packed {
    logic        ok;
    logic [11:0] page;
  } outcome_t;

  outcome_t   due_q[$];
  int         pages_cfg;
  bit         head_flag[NP];
  int         blk_ord[NP];
  int         nxt[NP];
  int         prv[NP];
  int         head[NORD];

  function automatic void wipe_lists();
    for (int i = 0; i < NP; i++) begin
      head_flag[i] = 0;
      blk_ord[i] = 0;
    end
    for (int i = 0; i < NORD; i++) head[i] = NIL;
  endfunction

  function automatic void push_free(int o, int p);
    nxt[p] = head[o];
    prv[p] = NIL;
    if (head[o] < NP) prv[head[o]] = p;
    head[o] = p;
    head_flag[p] = 1;
    blk_ord[p] = o;
  endfunction

  function automatic void take_out(int o, int p);
    int n;
    int pv;
    n = nxt[p];
    pv = prv[p];
    if (pv < NP) nxt[pv] = n;
    else head[o] = n;
    if (n < NP) prv[n] = pv;
    head_flag[p] = 0;
    blk_ord[p] = 0;
  endfunction

  function automatic void release_merge(int idx, int o);
    int b;
    while (o + 1 < NORD) begin
      b = idx ^ (1 << o);
      if (b >= NP || !head_flag[b] || blk_ord[b] != o) break;
      take_out(o, b);
      idx &= b;
      o++;
    end
    push_free(o, idx);
  endfunction

  function automatic outcome_t serve_request(logic [IN_DATA_W-1:0] d);
    cmd_e     c;
    int       idx;
    int       ord;
    int       n;
    int       p;
    int       o;
    outcome_t r;
    c = cmd_e'(d[1:0]);
    idx = int'(d[13:2]);
    ord = int'(d[17:14]);
    r = '0;
    case (c)
      CMD_ALLOC: begin
        for (int k = ord; k < NORD; k++) begin
          if (head[k] >= NP) continue;
          p = head[k];
          take_out(k, p);
          for (int s = k - 1; s >= ord; s--) push_free(s, p + (1 << s));
          r.ok = 1;
          r.page = p[11:0];
          break;
        end
      end
      CMD_FREE: begin
        if (ord < NORD && NP - idx >= (1 << ord) && !head_flag[idx]) begin
          release_merge(idx, ord);
          r.ok = 1;
        end
      end
      CMD_INIT: begin
        n = pages_cfg > NP ? NP : pages_cfg;
        p = 0;
        o = NORD - 1;
        wipe_lists();
        while (p < n) begin
          if (n - p >= (1 << o)) begin
            release_merge(p, o);
            p += 1 << o;
          end else if (o > 0) o--;
        end
        r.ok = 1;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got;
    outcome_t want;
    if (!rst_ni) begin
      pages_cfg <= NP;
      wipe_lists();
      due_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) pages_cfg <= int'(cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) due_q.push_back(serve_request(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{ok: m_axis_tdata[0], page: m_axis_tdata[12:1]};
        if (due_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result ok=%0d page=%0d", got.ok, got.page);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = due_q.pop_front();
          if (got !== want || m_axis_tdata[15:13] !== 3'b0) begin
            if (fail_count_o < 10)
              $display("mismatch: expected ok=%0d page=%0d, got ok=%0d page=%0d",
                       want.ok, want.page, got.ok, got.page);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= due_q.size();
    end
  end

endmodule

// File: dv/buddy_page_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator_test
// Drives allocate, free and initialise requests with random gaps and output
// stalls through several total_pages settings; the checker does the scoring.
// ----------------------------------------------------------------------------
module buddy_page_allocator_test import bpa_pkg::*;;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_W-1:0]      cfg_wdata_i;
  int                    fail_count;
  int                    pending;
  int                    cycles;
  bit                    hold_off;   // long receiver stall requested
  int                    live[$];    // pages we hold, packed page | order<<12

  localparam int CycleLimit = 3_000_000;

  buddy_page_allocator u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_wdata_i
  );

  buddy_page_allocator_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: give up well past the slowest legal run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stalls per result, plus one long hold-off on request.
  initial begin
    int w;
    m_axis_tready = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (w > 0) begin
        m_axis_tready <= 0;
        repeat (w) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Offer one request; hold until taken, first idling at random unless no_gap is set.
  task automatic send_request(cmd_e c, int page, int ord, bit no_gap = 0);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 7);
    if (w > 0) begin
      s_axis_tvalid <= 0;
      repeat (w) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {6'b0, ord[3:0], page[11:0], c};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Drain, let the block settle, then write total_pages.
  task automatic set_total(int n);
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= CFG_W'(n);
    @(posedge clk_i);
    cfg_we_i    <= 0;
  endtask

  // Mostly well-formed traffic: allocate, free what we hold, sometimes noise.
  task automatic random_phase(int count);
    int k;
    int e;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        e = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 4);
        send_request(CMD_ALLOC, $urandom, e);
      end else if (k < 85 && live.size() > 0) begin
        e = $urandom_range(0, live.size() - 1);
        send_request(CMD_FREE, live[e] & 12'hfff, live[e] >> 12);
        live.delete(e);
      end else if (k < 97) begin
        send_request(CMD_FREE, $urandom, $urandom_range(0, 15));
      end else if (k < 99) begin
        send_request(CMD_NONE, $urandom, $urandom);
      end else begin
        send_request(CMD_INIT, $urandom, $urandom);
        live.delete();
      end
      // Remember likely live blocks so frees hit real allocations.
      if (k < 45 && live.size() < 64)
        live.push_back(($urandom_range(0, 4095) & ~((1 << e) - 1)) | ((e % 11) << 12));
    end
  endtask

  initial begin
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    cfg_we_i      = 0;
    cfg_wdata_i   = '0;
    hold_off      = 0;
    rst_ni        = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty lists, init, extremes of every field, special cases.
    send_request(CMD_ALLOC, 0, 0);
    send_request(CMD_FREE, 4095, 0);
    send_request(CMD_INIT, 12'hfff, 4'hf);
    send_request(CMD_ALLOC, 0, 10);
    send_request(CMD_ALLOC, 0, 15);
    send_request(CMD_ALLOC, 0, 11);
    send_request(CMD_ALLOC, 0, 0);
    send_request(CMD_FREE, 0, 0);
    send_request(CMD_FREE, 0, 0);
    send_request(CMD_FREE, 4095, 1);
    send_request(CMD_FREE, 4094, 1);
    send_request(CMD_FREE, 100, 15);
    send_request(CMD_FREE, 3, 2);
    send_request(CMD_FREE, 1024, 10);
    send_request(CMD_NONE, 12'hfff, 4'hf);
    send_request(CMD_ALLOC, 0, 10);
    send_request(CMD_ALLOC, 0, 10);
    send_request(CMD_ALLOC, 0, 10);
    send_request(CMD_ALLOC, 0, 10);
    send_request(CMD_ALLOC, 0, 10);

    set_total(0);
    send_request(CMD_INIT, 0, 0);
    send_request(CMD_ALLOC, 0, 0);
    set_total(13'h1fff);
    send_request(CMD_INIT, 0, 0);
    random_phase(200);

    // Fill the block while results are held back.
    hold_off = 1;
    for (int i = 0; i < 20; i++) send_request(CMD_ALLOC, 0, 0, 1);

    set_total(1000);
    send_request(CMD_INIT, 0, 0);
    live.delete();
    random_phase(250);
    set_total(37);
    send_request(CMD_INIT, 0, 0);
    live.delete();
    random_phase(150);
    set_total(4096);
    send_request(CMD_INIT, 0, 0);
    live.delete();
    random_phase(150);

    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: buddy_page_allocator.f
sv/bpa_pkg.sv
sv/bpa_ctrl.sv
sv/bpa_datapath.sv
sv/buddy_page_allocator.sv
dv/buddy_page_allocator_checker.sv
dv/buddy_page_allocator_test.sv
